// ===== design/assert_macros.svh =====
// assertion macros used by the slab geometry calculator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sgc_pkg.sv =====
// types and fixed constants of the slab geometry calculator
package sgc_pkg;

   localparam int unsigned OBJ_SIZE_W = 21;
   localparam int unsigned ALIGN_W    = 13;
   localparam int unsigned PAD_W      = 12;
   localparam int unsigned STRIDE_W   = 22;
   localparam int unsigned OBJ_CNT_W  = 16;
   localparam int unsigned PCL_W      = 5;
   localparam int unsigned HDR_W      = 16;
   localparam int unsigned WASTE_W    = 16;

   localparam int unsigned SLAB_HEADER_BYTES = 24;
   localparam int unsigned ONSITE_THRESHOLD  = 512;

   typedef struct packed {
      logic [OBJ_SIZE_W-1:0] object_size;
      logic [ALIGN_W-1:0]    object_alignment;
      logic [PAD_W-1:0]      object_padding;
   } req_type;

   typedef struct packed {
      logic [OBJ_CNT_W-1:0] objects_per_slab;
      logic [PCL_W-1:0]     page_count_log2;
      logic                 header_on_slab;
      logic [HDR_W-1:0]     header_bytes;
      logic [WASTE_W-1:0]   wasted_bytes;
      logic                 failed;
   } rsp_type;

endpackage

// ===== design/slab_geometry_calculator_unit.sv =====
// slab geometry calculator: bit-serial divider driven by a doubling sequencer
//
//   channel   ports                          direction
//   request   req_valid req_stall req_data   in  (object size, alignment, padding)
//   response  rsp_valid rsp_stall rsp_data   out (slab geometry, failure flag)
//
// one request at a time; each page-count step runs a restoring divider that
// retires one quotient bit per cycle, and each doubling of the slab runs one
// more step; when the header sits on the slab, an initial division first
// estimates the bitmap from one page.
// reset is synchronous and clears the sequencer and the response valid.
// the next request is taken while a finished response still waits under stall.

`include "assert_macros.svh"

module slab_geometry_calculator_unit
   import sgc_pkg::*;
#(
   parameter int unsigned PAGE_BYTES    = 4096,
   parameter int unsigned MAX_DOUBLINGS = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned PAGE_W = $clog2(PAGE_BYTES + 1);
   localparam int unsigned SLAB_W = PAGE_W + MAX_DOUBLINGS - 1;
   localparam int unsigned WIDE_W = ((SLAB_W > STRIDE_W) ? SLAB_W : STRIDE_W) + 2;
   localparam int unsigned CNT_W  = $clog2(SLAB_W + 1);

   localparam logic [WIDE_W-1:0] PAGE_WIDE      = WIDE_W'(PAGE_BYTES);
   localparam logic [WIDE_W-1:0] ACCEPTED_WASTE = WIDE_W'(PAGE_BYTES / 16);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_START    = 4'd1;
   localparam logic [3:0] S_PREP     = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_INIT_RES = 4'd4;
   localparam logic [3:0] S_POST     = 4'd5;
   localparam logic [3:0] S_UPD      = 4'd6;
   localparam logic [3:0] S_CHECK    = 4'd7;
   localparam logic [3:0] S_FIN      = 4'd8;
   localparam logic [3:0] S_FIN2     = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   function automatic logic [WIDE_W-1:0] header_size(input logic [WIDE_W-1:0] cnt);
      logic [WIDE_W-1:0] part;
      part = WIDE_W'(SLAB_HEADER_BYTES) + (cnt >> 3);
      return part + WIDE_W'(|cnt[2:0]);
   endfunction

   function automatic logic [15:0] sat16(input logic [WIDE_W-1:0] v);
      return (|v[WIDE_W-1:16]) ? 16'hFFFF : v[15:0];
   endfunction

   logic [3:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   rsp_type             result_ff, result_in;
   logic                size_page_ff, size_page_in;
   logic [ALIGN_W-1:0]  align_ff, align_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [WIDE_W-1:0]   slab_ff, slab_in;
   logic [WIDE_W-1:0]   reserved_ff, reserved_in;
   logic [WIDE_W-1:0]   count_ff, count_in;
   logic [WIDE_W-1:0]   waste_ff, waste_in;
   logic [WIDE_W-1:0]   hsize_ff, hsize_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;
   logic [SLAB_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [PCL_W-1:0]    lg_ff, lg_in;
   logic                onsite_ff, onsite_in;
   logic                init_div_ff, init_div_in;
   logic                first_ff, first_in;
   logic                no_room_ff, no_room_in;

   logic [WIDE_W-1:0]   slab_diff;
   logic [STRIDE_W:0]   rem_shift;
   logic                rem_fits;
   logic                retry;
   logic                moved;
   rsp_type             fail_result;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slab_diff = slab_ff - reserved_ff;
   assign rem_shift = {rem_ff, quo_ff[SLAB_W-1]};
   assign rem_fits  = (rem_shift >= {1'b0, stride_ff});
   assign retry     = (count_ff == '0) || (waste_ff > ACCEPTED_WASTE) ||
                      (waste_ff < reserved_ff);
   assign moved     = !onsite_ff && (waste_ff >= hsize_ff + WIDE_W'(align_ff));

   always_comb begin
      fail_result        = '0;
      fail_result.failed = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      result_in    = result_ff;
      size_page_in = size_page_ff;
      align_in     = align_ff;
      stride_in    = stride_ff;
      slab_in      = slab_ff;
      reserved_in  = reserved_ff;
      count_in     = count_ff;
      waste_in     = waste_ff;
      hsize_in     = hsize_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_cnt_in   = bit_cnt_ff;
      lg_in        = lg_ff;
      onsite_in    = onsite_ff;
      init_div_in  = init_div_ff;
      first_in     = first_ff;
      no_room_in   = no_room_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               size_page_in = (req_data.object_size == OBJ_SIZE_W'(PAGE_BYTES));
               align_in     = req_data.object_alignment;
               stride_in    = STRIDE_W'(req_data.object_size) +
                              STRIDE_W'(req_data.object_padding);
               state_in     = S_START;
            end
         end
         S_START: begin
            lg_in       = '0;
            slab_in     = PAGE_WIDE;
            reserved_in = '0;
            first_in    = 1'b1;
            if (stride_ff == '0) begin
               result_in = fail_result;
               state_in  = S_OUT;
            end else begin
               // small strides keep the header on the slab; size it from one page first
               onsite_in   = (stride_ff < STRIDE_W'(ONSITE_THRESHOLD));
               init_div_in = (stride_ff < STRIDE_W'(ONSITE_THRESHOLD));
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            no_room_in = (slab_ff <= reserved_ff);
            quo_in     = (slab_ff <= reserved_ff) ? '0 : slab_diff[SLAB_W-1:0];
            rem_in     = '0;
            bit_cnt_in = CNT_W'(SLAB_W);
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (rem_fits) begin
               rem_in = STRIDE_W'(rem_shift - {1'b0, stride_ff});
            end else begin
               rem_in = rem_shift[STRIDE_W-1:0];
            end
            quo_in     = {quo_ff[SLAB_W-2:0], rem_fits};
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            if (bit_cnt_ff == CNT_W'(1)) begin
               state_in = init_div_ff ? S_INIT_RES : S_POST;
            end
         end
         S_INIT_RES: begin
            reserved_in = header_size(WIDE_W'(quo_ff)) + WIDE_W'(align_ff);
            init_div_in = 1'b0;
            state_in    = S_PREP;
         end
         S_POST: begin
            // slab minus count times stride equals remainder plus reserved space
            count_in = no_room_ff ? '0 : WIDE_W'(quo_ff);
            waste_in = no_room_ff ? slab_ff : WIDE_W'(rem_ff) + reserved_ff;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (onsite_ff && !first_ff) begin
               reserved_in = header_size(count_ff) + WIDE_W'(align_ff);
            end
            first_in = 1'b0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (retry) begin
               if (({1'b0, lg_ff} + 6'd1) >= 6'(MAX_DOUBLINGS)) begin
                  result_in = fail_result;
                  state_in  = S_OUT;
               end else begin
                  lg_in    = lg_ff + PCL_W'(1);
                  slab_in  = slab_ff << 1;
                  state_in = S_PREP;
               end
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            hsize_in = header_size(count_ff);
            state_in = S_FIN2;
         end
         S_FIN2: begin
            result_in.failed         = 1'b0;
            result_in.wasted_bytes   = sat16(waste_ff);
            result_in.header_on_slab = !size_page_ff && (onsite_ff || moved);
            if (size_page_ff) begin
               // page-sized object: sixteen objects on sixteen pages, header off the slab
               result_in.objects_per_slab = OBJ_CNT_W'(16);
               result_in.page_count_log2  = PCL_W'(4);
               result_in.header_bytes     = HDR_W'(SLAB_HEADER_BYTES + 2);
            end else begin
               result_in.objects_per_slab = sat16(count_ff);
               result_in.page_count_log2  = lg_ff;
               result_in.header_bytes     = onsite_ff ? sat16(reserved_ff) : sat16(hsize_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      result_ff    <= result_in;
      size_page_ff <= size_page_in;
      align_ff     <= align_in;
      stride_ff    <= stride_in;
      slab_ff      <= slab_in;
      reserved_ff  <= reserved_in;
      count_ff     <= count_in;
      waste_ff     <= waste_in;
      hsize_ff     <= hsize_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      bit_cnt_ff   <= bit_cnt_in;
      lg_ff        <= lg_in;
      onsite_ff    <= onsite_in;
      init_div_ff  <= init_div_in;
      first_ff     <= first_in;
      no_room_ff   <= no_room_in;
   end

   `ASSERT_SAME(a_fail_clean, clock, reset, rsp_valid && rsp_data.failed, rsp_data.objects_per_slab == '0 && rsp_data.header_bytes == '0 && rsp_data.wasted_bytes == '0 && rsp_data.page_count_log2 == '0 && !rsp_data.header_on_slab, "failed response carries nonzero geometry")
   `ASSERT_SAME(a_fit_nonempty, clock, reset, rsp_valid && !rsp_data.failed, rsp_data.objects_per_slab != '0, "successful response with no objects")
   `ASSERT_NEXT(a_accept_start, clock, reset, req_valid && !req_stall, state_ff == S_START, "accepted request did not start the sequencer")
   `ASSERT_SAME(a_lg_bound, clock, reset, state_ff != S_IDLE, ({1'b0, lg_ff} < 6'(MAX_DOUBLINGS)) || state_ff == S_START || state_ff == S_OUT, "page count exponent beyond doubling limit")

endmodule

// ===== tb/slab_geometry_calculator_unit_test.sv =====
// self-checking testbench for the slab geometry calculator
`timescale 1ns / 1ps

module slab_geometry_calculator_unit_test;
   import sgc_pkg::*;

   localparam longint unsigned SLAB_PAGE_BYTES = 4096;
   localparam longint unsigned WASTE_LIMIT     = SLAB_PAGE_BYTES / 16;
   localparam int unsigned     DOUBLING_LIMIT  = 31;
   localparam int unsigned     HOLD_CYCLES     = 4000;
   localparam int unsigned     STALL_LIMIT     = 20000;
   localparam int unsigned     DRAIN_CYCLES    = 20;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type     pending_geometry_q[$];
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   bit          no_idling;
   bit          hold_pending;

   slab_geometry_calculator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // header plus one bitmap bit per object, rounded up to bytes
   function automatic longint unsigned header_with_bitmap(input longint unsigned n);
      return SLAB_HEADER_BYTES + (n >> 3) + (((n & 7) != 0) ? 1 : 0);
   endfunction

   function automatic logic [15:0] clamp16(input longint unsigned v);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic rsp_type predict_geometry(input req_type r);
      longint unsigned obj_bytes, align_bytes, stride, reserved, count, waste, slab;
      bit              onsite;
      int unsigned     lg;
      rsp_type         res;
      obj_bytes   = 64'(r.object_size);
      align_bytes = 64'(r.object_alignment);
      stride      = obj_bytes + 64'(r.object_padding);
      reserved    = 0;
      onsite      = 1'b0;
      lg          = 0;
      res         = '0;
      if (stride == 0) begin
         res.failed = 1'b1;
         return res;
      end
      slab = SLAB_PAGE_BYTES;
      if (stride < ONSITE_THRESHOLD) begin
         onsite   = 1'b1;
         reserved = header_with_bitmap(slab / stride) + align_bytes;
      end
      count = (slab > reserved) ? (slab - reserved) / stride : 0;
      waste = slab - count * stride;
      while (count == 0 || waste > WASTE_LIMIT || waste < reserved) begin
         if (lg + 1 >= DOUBLING_LIMIT) begin
            res.failed = 1'b1;
            return res;
         end
         lg++;
         slab  = SLAB_PAGE_BYTES << lg;
         count = (slab > reserved) ? (slab - reserved) / stride : 0;
         waste = slab - count * stride;
         if (onsite)
            reserved = header_with_bitmap(count) + align_bytes;
      end
      // an off-site header moves in when the waste can hold it
      if (!onsite && waste >= header_with_bitmap(count) + align_bytes)
         onsite = 1'b1;
      if (obj_bytes == SLAB_PAGE_BYTES) begin
         count    = 16;
         lg       = 4;
         onsite   = 1'b0;
         reserved = 0;
      end
      if (reserved == 0)
         reserved = header_with_bitmap(count);
      res.objects_per_slab = clamp16(count);
      res.page_count_log2  = lg[4:0];
      res.header_on_slab   = onsite;
      res.header_bytes     = clamp16(reserved);
      res.wasted_bytes     = clamp16(waste);
      res.failed           = 1'b0;
      return res;
   endfunction

   function automatic req_type random_geometry_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         r.object_size = '0;
      else if (pick < 40)
         r.object_size = OBJ_SIZE_W'($urandom_range(1, 511));
      else if (pick < 60)
         r.object_size = OBJ_SIZE_W'($urandom_range(512, 8192));
      else if (pick < 65)
         r.object_size = 21'd4096;
      else if (pick < 80)
         r.object_size = OBJ_SIZE_W'($urandom_range(8193, 65536));
      else
         r.object_size = OBJ_SIZE_W'($urandom_range(65537, 1048576));
      pick = $urandom_range(0, 99);
      if (pick < 40)
         r.object_alignment = '0;
      else if (pick < 70)
         r.object_alignment = 13'd1 << $urandom_range(0, 12);
      else
         r.object_alignment = ALIGN_W'($urandom_range(0, 4096));
      pick = $urandom_range(0, 99);
      if (pick < 50)
         r.object_padding = '0;
      else if (pick < 75)
         r.object_padding = PAD_W'($urandom_range(0, 63));
      else
         r.object_padding = PAD_W'($urandom_range(0, 4095));
      return r;
   endfunction

   function automatic req_type make_request(input int unsigned sz, input int unsigned al,
                                            input int unsigned pd);
      req_type r;
      r.object_size      = OBJ_SIZE_W'(sz);
      r.object_alignment = ALIGN_W'(al);
      r.object_padding   = PAD_W'(pd);
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_geometry_request(input req_type item);
      int unsigned gap;
      gap = (!no_idling && $urandom_range(0, 99) < 7) ? $urandom_range(1, 60) : 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do
         @(posedge clock);
      while (req_stall);
      pending_geometry_q.push_back(predict_geometry(item));
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   task automatic test_corner_cases();
      no_idling = 1'b0;
      send_geometry_request(make_request(0, 0, 0));            // zero stride
      send_geometry_request(make_request(0, 0, 1));
      send_geometry_request(make_request(0, 0, 4095));
      send_geometry_request(make_request(1, 0, 0));
      send_geometry_request(make_request(4096, 0, 0));         // page-sized object
      send_geometry_request(make_request(4096, 64, 100));
      send_geometry_request(make_request(511, 0, 0));
      send_geometry_request(make_request(510, 0, 1));
      send_geometry_request(make_request(512, 0, 0));
      send_geometry_request(make_request(1, 4096, 0));         // reserved beyond one page
      send_geometry_request(make_request(100, 4096, 0));
      send_geometry_request(make_request(200, 4095, 0));
      send_geometry_request(make_request(1048576, 4096, 4095));
      send_geometry_request(make_request(1048576, 0, 0));
      send_geometry_request(make_request(600, 0, 0));          // off-site may move on-site
      send_geometry_request(make_request(2048, 0, 0));
      send_geometry_request(make_request(1000, 8, 24));
      send_geometry_request(make_request(64, 64, 0));
      send_geometry_request(make_request(3000, 0, 0));
      send_geometry_request(make_request(8, 1, 0));
      send_geometry_request(make_request(2047, 2048, 2048));
   endtask

   task automatic test_random_traffic(input int unsigned n);
      no_idling = 1'b0;
      repeat (n) send_geometry_request(random_geometry_request());
   endtask

   task automatic test_steady_stream(input int unsigned n);
      no_idling = 1'b1;
      repeat (n) send_geometry_request(random_geometry_request());
      no_idling = 1'b0;
   endtask

   // receiver holds off long enough for the request side to back up
   task automatic test_output_backpressure(input int unsigned n);
      no_idling    = 1'b0;
      hold_pending = 1'b1;
      repeat (n) send_geometry_request(random_geometry_request());
   endtask

   // receiver side
   initial begin
      rsp_stall    = 1'b0;
      hold_pending = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_pending = 1'b0;
         end else begin
            rsp_stall = !reset && !no_idling && ($urandom_range(0, 99) < 7);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_geometry_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
         end else begin
            want = pending_geometry_q.pop_front();
            check_field("objects_per_slab", 64'(want.objects_per_slab),
                        64'(rsp_data.objects_per_slab));
            check_field("page_count_log2", 64'(want.page_count_log2),
                        64'(rsp_data.page_count_log2));
            check_field("header_on_slab", 64'(want.header_on_slab),
                        64'(rsp_data.header_on_slab));
            check_field("header_bytes", 64'(want.header_bytes),
                        64'(rsp_data.header_bytes));
            check_field("wasted_bytes", 64'(want.wasted_bytes),
                        64'(rsp_data.wasted_bytes));
            check_field("failed", 64'(want.failed), 64'(rsp_data.failed));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("slab_geometry_calculator_unit_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      no_idling      = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_corner_cases();
      test_random_traffic(250);
      test_steady_stream(100);
      test_output_backpressure(30);
      test_random_traffic(120);
      req_valid = 1'b0;
      while (pending_geometry_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_geometry_q.size() == 0)
         $display("slab_geometry_calculator_unit_test passed");
      else
         $display("slab_geometry_calculator_unit_test failed");
      $finish;
   end

endmodule

// ===== slab_geometry_calculator_unit.f =====
+incdir+design
design/sgc_pkg.sv
design/slab_geometry_calculator_unit.sv
tb/slab_geometry_calculator_unit_test.sv
